>>> rtl/fpf_pkg.sv
// ----------------------------------------------------------------------------
// fpf_pkg: shared types and constants of the focal-point phase generator
// Field widths, fixed-point formats, register codes, reset values, the
// sequencer state type and the start/status bundles of the iterative units.
// ----------------------------------------------------------------------------
package fpf_pkg;

  // Interface field widths.
  localparam int COORD_W     = 14;
  localparam int CPM_W       = 24;
  localparam int PITCH_W     = 12;
  localparam int CHAN_W      = 6;
  localparam int PHASE_OUT_W = 9;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_PER_MM = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_PITCH = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_X_ORIGIN = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_Z_ORIGIN = 4'd3;

  localparam logic [CPM_W-1:0]          CPM_RESET   = 24'd3913053;
  localparam logic [PITCH_W-1:0]        PITCH_RESET = 12'd160;
  localparam logic signed [COORD_W-1:0] X_ORG_RESET = 14'sd720;
  localparam logic signed [COORD_W-1:0] Z_ORG_RESET = -14'sd720;

  // Default array geometry.
  localparam int CHANNELS_DEF     = 50;
  localparam int GRID_COLUMNS_DEF = 10;
  localparam int PHASE_STEPS_DEF  = 512;

  // Datapath widths. With at most 64 channels and a 12-bit pitch a grid
  // offset stays below 2^18, so positions and deltas fit 20 bits signed.
  localparam int POS_W      = 20;
  localparam int MAG_W      = 20;
  localparam int SUM_W      = 40;   // dx^2 + dy^2 + dz^2
  localparam int SQ_SHIFT   = 22;   // 11 fraction bits on the root
  localparam int SQ_W       = SUM_W + SQ_SHIFT;
  localparam int ROOT_W     = 31;
  localparam int ROOT_ITERS = ROOT_W;
  localparam int PROD_W     = ROOT_W + CPM_W;
  localparam int N_SHIFT    = 31;   // 16 (Q8.16) + 4 (1/16 mm) + 11 fraction
  localparam int N_W        = PROD_W - N_SHIFT;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM,
    ST_ROOT,
    ST_SCALE,
    ST_MOD_GO,
    ST_MOD,
    ST_PUSH
  } state_t;

  // Multiplier operand selection.
  typedef enum logic [1:0] {
    MUL_DX,
    MUL_DY,
    MUL_DZ,
    MUL_SCALE
  } mul_sel_t;

  // Control into and status out of an iterative unit.
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/phased_array_focus_phases.sv
// ----------------------------------------------------------------------------
// phased_array_focus_phases: focal-point drive phases for a transducer grid
// For each focal point, produces one drive phase per transducer of the grid.
// ----------------------------------------------------------------------------
// One focal point (focus_x, focus_y, focus_z in 1/16 mm) is taken when the
// block is idle; it then delivers CHANNELS results in channel order, the last
// one marked, each phase being (-floor(r * counts_per_mm)) mod PHASE_STEPS for
// the distance r from the transducer to the focus. Results are worked out one
// channel at a time by a single multiplier (three squares and the scale
// product) and a 31-step square root unit; when PHASE_STEPS is not a power
// of two, an iterative phase reduction follows the scale product. A stalled
// output holds the sequencer until the output register is free. in_stall
// stays high from the accepted focal point until its last result is in the
// output register; that last result may still wait there while the next
// point is taken. The user must write registers with cfg_valid only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high and writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module phased_array_focus_phases
  import fpf_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int PHASE_STEPS  = PHASE_STEPS_DEF
)
(
  input  logic                          clk,
  input  logic                          rst,
  // Focal point channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_W-1:0]     focus_x,
  input  logic signed [COORD_W-1:0]     focus_y,
  input  logic signed [COORD_W-1:0]     focus_z,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAN_W-1:0]             channel,
  output logic [PHASE_OUT_W-1:0]        phase,
  output logic                          last,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int PH_W = $clog2(PHASE_STEPS);
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);
  localparam logic [CHAN_W-1:0] LAST_COL  = CHAN_W'(GRID_COLUMNS - 1);

  // Configuration registers
  logic [CPM_W-1:0]          counts_per_mm;
  logic [PITCH_W-1:0]        element_pitch;
  logic signed [COORD_W-1:0] grid_x_origin;
  logic signed [COORD_W-1:0] grid_z_origin;

  // Sequencer and frame counters
  state_t                    state;
  state_t                    state_next;
  logic [CHAN_W-1:0]         chan_cnt;
  logic [CHAN_W-1:0]         col_cnt;

  // Datapath registers
  logic signed [COORD_W-1:0] held_x;
  logic signed [COORD_W-1:0] held_y;
  logic signed [COORD_W-1:0] held_z;
  logic signed [POS_W-1:0]   x_pos;
  logic signed [POS_W-1:0]   z_pos;
  logic [MAG_W-1:0]          dx_mag;
  logic [MAG_W-1:0]          dy_mag;
  logic [MAG_W-1:0]          dz_mag;
  logic [PROD_W-1:0]         prod;
  logic [SUM_W-1:0]          acc;

  // Combinational signals
  logic                      in_xfer;
  logic                      push;
  logic                      out_free;
  logic                      frame_end;
  mul_sel_t                  mul_sel;
  logic [ROOT_W-1:0]         mul_a;
  logic [CPM_W-1:0]          mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic signed [POS_W-1:0]   dx;
  logic signed [POS_W-1:0]   dz;
  logic signed [POS_W-1:0]   pitch_ext;
  logic [SUM_W-1:0]          sum_sq;
  unit_ctl_t                 root_ctl;
  unit_sts_t                 root_sts;
  logic [ROOT_W-1:0]         root;
  unit_ctl_t                 mod_ctl;
  unit_sts_t                 mod_sts;
  logic [PH_W-1:0]           mod_phase;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign frame_end = chan_cnt == LAST_CHAN;
  assign pitch_ext = $signed(POS_W'(element_pitch));

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_mm <= CPM_RESET;
      element_pitch <= PITCH_RESET;
      grid_x_origin <= X_ORG_RESET;
      grid_z_origin <= Z_ORG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNTS_PER_MM: counts_per_mm <= cfg_data[CPM_W-1:0];
        REG_ELEMENT_PITCH: element_pitch <= cfg_data[PITCH_W-1:0];
        REG_GRID_X_ORIGIN: grid_x_origin <= $signed(cfg_data[COORD_W-1:0]);
        REG_GRID_Z_ORIGIN: grid_z_origin <= $signed(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DELTA;
      ST_DELTA:  state_next = ST_SQ_X;
      ST_SQ_X:   state_next = ST_SQ_Y;
      ST_SQ_Y:   state_next = ST_SQ_Z;
      ST_SQ_Z:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (root_sts.done) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_MOD_GO;
      ST_MOD_GO: state_next = ST_MOD;
      ST_MOD:    if (mod_sts.done) state_next = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_next = frame_end ? ST_IDLE : ST_DELTA;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall       = 1'b1;
    root_ctl.start = 1'b0;
    mod_ctl.start  = 1'b0;
    push           = 1'b0;
    mul_sel        = MUL_SCALE;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SQ_X:   mul_sel = MUL_DX;
      ST_SQ_Y:   mul_sel = MUL_DY;
      ST_SQ_Z:   mul_sel = MUL_DZ;
      ST_SUM:    root_ctl.start = 1'b1;
      ST_MOD_GO: mod_ctl.start = 1'b1;
      ST_PUSH:   push = out_free;
      default: ;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (mul_sel)
      MUL_DX: begin
        mul_a = ROOT_W'(dx_mag);
        mul_b = CPM_W'(dx_mag);
      end
      MUL_DY: begin
        mul_a = ROOT_W'(dy_mag);
        mul_b = CPM_W'(dy_mag);
      end
      MUL_DZ: begin
        mul_a = ROOT_W'(dz_mag);
        mul_b = CPM_W'(dz_mag);
      end
      default: begin
        mul_a = root;
        mul_b = counts_per_mm;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign sum_sq = acc + prod[SUM_W-1:0];
  assign dx     = POS_W'(held_x) - x_pos;
  assign dz     = POS_W'(held_z) - z_pos;

  // Focal point capture and the running transducer position.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      held_x <= focus_x;
      held_y <= focus_y;
      held_z <= focus_z;
      x_pos  <= POS_W'(grid_x_origin);
      z_pos  <= POS_W'(grid_z_origin);
    end else if (push && !frame_end) begin
      if (col_cnt == LAST_COL) begin
        x_pos <= x_pos - pitch_ext;
        z_pos <= POS_W'(grid_z_origin);
      end else begin
        z_pos <= z_pos + pitch_ext;
      end
    end
  end

  // Channel and column counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= '0;
      col_cnt  <= '0;
    end else if (in_xfer) begin
      chan_cnt <= '0;
      col_cnt  <= '0;
    end else if (push) begin
      if (frame_end) begin
        chan_cnt <= '0;
        col_cnt  <= '0;
      end else begin
        chan_cnt <= chan_cnt + 1'b1;
        col_cnt  <= (col_cnt == LAST_COL) ? '0 : col_cnt + 1'b1;
      end
    end
  end

  // Delta magnitudes; the sign drops out of the squares.
  always_ff @(posedge clk) begin
    if (state == ST_DELTA) begin
      dx_mag <= dx[POS_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      dz_mag <= dz[POS_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      dy_mag <= held_y[COORD_W-1] ? MAG_W'(-POS_W'(held_y)) : MAG_W'(held_y);
    end
  end

  // Product register and square accumulation.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (state == ST_SQ_Y) begin
      acc <= prod[SUM_W-1:0];
    end else if (state == ST_SQ_Z) begin
      acc <= sum_sq;
    end
  end

  fpf_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (root_ctl),
    .operand (sum_sq),
    .sts     (root_sts),
    .root    (root)
  );

  fpf_phase_mod #(
    .PHASE_STEPS (PHASE_STEPS)
  ) u_phase_mod (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mod_ctl),
    .n     (prod[PROD_W-1:N_SHIFT]),
    .sts   (mod_sts),
    .phase (mod_phase)
  );

  // Output register; a transfer frees it for the next channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      channel <= chan_cnt;
      phase   <= PHASE_OUT_W'(mod_phase);
      last    <= frame_end;
    end
  end

  // A new focal point always starts the frame at channel zero.
  ap_frame_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (chan_cnt == '0 && col_cnt == '0))
    else $error("frame did not start at channel zero");

  // The column counter never runs past the grid width.
  ap_col_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= LAST_COL)
    else $error("column counter out of range");

  // A result is only loaded while the square root and phase units are idle.
  ap_push_idle_units: assert property (@(posedge clk) disable iff (rst)
    push |-> (!root_sts.busy && !mod_sts.busy))
    else $error("result loaded while a unit is still working");

endmodule

>>> rtl/fpf_isqrt.sv
// ----------------------------------------------------------------------------
// fpf_isqrt: iterative integer square root
// Takes the squared distance, scales it by 2^22 and produces the truncated
// root with one result bit per cycle, using a shared compare and subtract.
// ----------------------------------------------------------------------------
module fpf_isqrt
  import fpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  unit_ctl_t         ctl,
  input  logic [SUM_W-1:0]  operand,
  output unit_sts_t         sts,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_ITERS);
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ROOT_ITERS - 1);

  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  bitm;
  logic [CNT_W-1:0] iter;
  logic             busy;
  logic             done;
  logic [SQ_W:0]    trial;
  logic             take;

  // One trial subtraction of (res + bit) per cycle.
  assign trial = {1'b0, res} + {1'b0, bitm};
  assign take  = {1'b0, rem} >= trial;

  // Control: busy for a fixed number of iterations, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, partial root and bit position.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= {operand, {SQ_SHIFT{1'b0}}};
      res  <= '0;
      bitm <= SQ_W'(1) << (2 * (ROOT_ITERS - 1));
    end else if (busy) begin
      if (take) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign root     = res[ROOT_W-1:0];

  // A new root is never requested while one is in progress.
  ap_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy)
    else $error("square root restarted while busy");

  // The done pulse follows the final iteration.
  ap_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && iter == LAST_ITER && !ctl.start) |=> (done && !busy))
    else $error("square root did not finish after its last iteration");

endmodule

>>> rtl/fpf_phase_mod.sv
// ----------------------------------------------------------------------------
// fpf_phase_mod: phase count reduction
// Turns the path count n into (-n) mod PHASE_STEPS. A power-of-two step
// count is a mask; any other count is reduced by shifted compare and
// subtract, one bit of n per cycle.
// ----------------------------------------------------------------------------
module fpf_phase_mod
  import fpf_pkg::*;
#(
  parameter int PHASE_STEPS = PHASE_STEPS_DEF
)
(
  input  logic                           clk,
  input  logic                           rst,
  input  unit_ctl_t                      ctl,
  input  logic [N_W-1:0]                 n,
  output unit_sts_t                      sts,
  output logic [$clog2(PHASE_STEPS)-1:0] phase
);

  localparam int  PH_W    = $clog2(PHASE_STEPS);
  localparam bit  IS_POW2 = (PHASE_STEPS & (PHASE_STEPS - 1)) == 0;

  logic            busy;
  logic            done;
  logic [PH_W-1:0] phase_q;

  generate
    if (IS_POW2) begin : g_mask
      logic [N_W-1:0] neg_n;

      // Negation modulo a power of two keeps the low bits.
      assign neg_n = N_W'(0) - n;

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= ctl.start;
        end
      end

      always_ff @(posedge clk) begin
        if (ctl.start) begin
          phase_q <= neg_n[PH_W-1:0];
        end
      end

      assign busy = 1'b0;
    end else begin : g_reduce
      localparam int CMP_W = N_W + PH_W;
      localparam int K_W   = $clog2(N_W);

      logic [N_W-1:0]   rem;
      logic [K_W-1:0]   k;
      logic             run;
      logic             fin;
      logic [CMP_W-1:0] p_shift;

      assign p_shift = CMP_W'(PHASE_STEPS) << k;

      // Control: one shift position per cycle; fin then forms the phase and raises done.
      always_ff @(posedge clk) begin
        if (rst) begin
          run  <= 1'b0;
          fin  <= 1'b0;
          done <= 1'b0;
          k    <= '0;
        end else begin
          fin  <= 1'b0;
          done <= fin;
          if (ctl.start) begin
            run <= 1'b1;
            k   <= K_W'(N_W - 1);
          end else if (run) begin
            k <= k - 1'b1;
            if (k == '0) begin
              run <= 1'b0;
              fin <= 1'b1;
            end
          end
        end
      end

      // Restoring reduction of n by PHASE_STEPS.
      always_ff @(posedge clk) begin
        if (ctl.start) begin
          rem <= n;
        end else if (run && (CMP_W'(rem) >= p_shift)) begin
          rem <= rem - p_shift[N_W-1:0];
        end
      end

      // Negate the remainder modulo PHASE_STEPS.
      always_ff @(posedge clk) begin
        if (fin) begin
          if (rem == '0) begin
            phase_q <= '0;
          end else begin
            phase_q <= PH_W'(PHASE_STEPS) - rem[PH_W-1:0];
          end
        end
      end

      assign busy = run | fin;
    end
  endgenerate

  assign sts.busy = busy;
  assign sts.done = done;
  assign phase    = phase_q;

  // A finished phase always lies inside the step range.
  ap_phase_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, phase_q} < (PH_W + 1)'(PHASE_STEPS)))
    else $error("phase outside the step range");

endmodule
